// ===== rtl/mbrot_pkg.sv =====
`default_nettype none
package mbrot_pkg;

    localparam int FRAC_BITS = 28;
    localparam int COORD_W   = 32;
    localparam int PROD_W    = 2 * COORD_W;
    localparam int SQ_W      = PROD_W - FRAC_BITS;
    localparam int XY_W      = PROD_W - FRAC_BITS + 1;
    localparam int WIDE_W    = 42;
    localparam int IDX_W     = 10;
    localparam int CNT_W     = 16;
    localparam int STEP_W    = 29;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [PROD_W-1:0]  t_prod;
    typedef logic signed [WIDE_W-1:0]  t_wide;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REAL_ORIGIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REAL_STEP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAG_ORIGIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IMAG_STEP   = 3'd4;

    localparam logic [CNT_W-1:0]  RST_MAX_ITER    = 16'd2000;
    localparam t_coord            RST_REAL_ORIGIN = -32'sd536870912;
    localparam logic [STEP_W-1:0] RST_REAL_STEP   = 29'd1006633;
    localparam t_coord            RST_IMAG_ORIGIN = -32'sd335544320;
    localparam logic [STEP_W-1:0] RST_IMAG_STEP   = 29'd838861;

    localparam t_wide ESCAPE_LIMIT = t_wide'(4) <<< FRAC_BITS;

    // clamp to the signed coordinate range
    function automatic t_coord sat_coord(input t_wide v);
        logic all_same;
        all_same = (v[WIDE_W-1:COORD_W-1] == '0) || (v[WIDE_W-1:COORD_W-1] == '1);
        if (all_same) begin
            return v[COORD_W-1:0];
        end else if (v[WIDE_W-1]) begin
            return {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            return {1'b0, {(COORD_W-1){1'b1}}};
        end
    endfunction

endpackage
`default_nettype wire

// ===== rtl/mbrot_mul.sv =====
`default_nettype none
module mbrot_mul (
    input  wire                  i_clk,
    input  mbrot_pkg::t_coord    i_a,
    input  mbrot_pkg::t_coord    i_b,
    output mbrot_pkg::t_prod     o_prod
);
    import mbrot_pkg::*;

    t_prod r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule
`default_nettype wire

// ===== rtl/mandelbrot_escape_time_pixel_core.sv =====
// Sequence: setup states CR, CI and CIW form c; each iteration runs XX, YY, XY
//   and UPD, the escape test in XY can end the loop early, and the result goes out
//   through DONE, which waits for the output to be free; a zero limit goes straight to DONE.
// Flow: one pixel at a time, next input taken from the cycle the result appears;
//   the single 32x32 multiplier is shared by the c setup products, x*x, y*y and x*y.
// Reset: synchronous active low; returns to idle, drops the output, and loads
//   the default view (-2.0 - 1.25i, 800 pixels across) with a limit of 2000.
`default_nettype none
module mandelbrot_escape_time_pixel_core (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire [mbrot_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [mbrot_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    input  wire                             i_in_valid,
    output logic                            o_in_ready,
    input  wire [mbrot_pkg::IDX_W-1:0]      i_row_index,
    input  wire [mbrot_pkg::IDX_W-1:0]      i_column_index,
    output logic                            o_out_valid,
    input  wire                             i_out_ready,
    output logic [mbrot_pkg::CNT_W-1:0]     o_iteration_count,
    output logic                            o_inside_set
);
    import mbrot_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CR   = 4'd1;
    localparam logic [3:0] S_CI   = 4'd2;
    localparam logic [3:0] S_CIW  = 4'd3;
    localparam logic [3:0] S_XX   = 4'd4;
    localparam logic [3:0] S_YY   = 4'd5;
    localparam logic [3:0] S_XY   = 4'd6;
    localparam logic [3:0] S_UPD  = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    logic [3:0]        r_state;
    logic [3:0]        n_state;
    logic [CNT_W-1:0]  r_max_iter;
    t_coord            r_real_origin;
    logic [STEP_W-1:0] r_real_step;
    t_coord            r_imag_origin;
    logic [STEP_W-1:0] r_imag_step;

    logic [IDX_W-1:0]  r_row;
    logic [IDX_W-1:0]  r_col;
    t_coord            r_cr;
    t_coord            r_ci;
    t_coord            r_x;
    t_coord            r_y;
    logic signed [SQ_W-1:0] r_xsq;
    logic signed [SQ_W-1:0] r_ysq;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;

    logic              r_out_valid;
    logic [CNT_W-1:0]  r_out_count;
    logic              r_out_inside;

    t_coord            mul_a;
    t_coord            mul_b;
    t_prod             prod;
    logic signed [SQ_W-1:0] prod_sq;
    logic signed [XY_W-1:0] prod_xy;
    t_wide             sq_sum;
    t_coord            c_sat;
    t_coord            nx;
    t_coord            ny;
    logic              in_acc;
    logic              out_load;

    mbrot_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    assign in_acc      = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE) && !r_out_valid;
    assign out_load    = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    // floor(p / 2^28) and floor(p / 2^27)
    assign prod_sq = prod[PROD_W-1:FRAC_BITS];
    assign prod_xy = prod[PROD_W-1:FRAC_BITS-1];
    assign sq_sum  = t_wide'(r_xsq) + t_wide'(prod_sq);
    assign c_sat   = sat_coord(t_wide'((r_state == S_CI) ? r_real_origin : r_imag_origin)
                               + t_wide'(prod));
    assign nx      = sat_coord(t_wide'(r_xsq) - t_wide'(r_ysq) + t_wide'(r_cr));
    assign ny      = sat_coord(t_wide'(prod_xy) + t_wide'(r_ci));
    assign n_count = r_count + CNT_W'(1);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_CR: begin
                mul_a = COORD_W'(r_col);
                mul_b = COORD_W'(r_real_step);
            end
            S_CI: begin
                mul_a = COORD_W'(r_row);
                mul_b = COORD_W'(r_imag_step);
            end
            S_XX: begin
                mul_a = r_x;
                mul_b = r_x;
            end
            S_YY: begin
                mul_a = r_y;
                mul_b = r_y;
            end
            S_XY: begin
                mul_a = r_x;
                mul_b = r_y;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = (r_max_iter == '0) ? S_DONE : S_CR;
                end
            end
            S_CR:  n_state = S_CI;
            S_CI:  n_state = S_CIW;
            S_CIW: n_state = S_XX;
            S_XX:  n_state = S_YY;
            S_YY:  n_state = S_XY;
            S_XY:  n_state = (sq_sum >= ESCAPE_LIMIT) ? S_DONE : S_UPD;
            S_UPD: n_state = (n_count == r_max_iter) ? S_DONE : S_XX;
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_max_iter    <= RST_MAX_ITER;
            r_real_origin <= RST_REAL_ORIGIN;
            r_real_step   <= RST_REAL_STEP;
            r_imag_origin <= RST_IMAG_ORIGIN;
            r_imag_step   <= RST_IMAG_STEP;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    REG_MAX_ITER:    r_max_iter    <= i_cfg_data[CNT_W-1:0];
                    REG_REAL_ORIGIN: r_real_origin <= i_cfg_data;
                    REG_REAL_STEP:   r_real_step   <= i_cfg_data[STEP_W-1:0];
                    REG_IMAG_ORIGIN: r_imag_origin <= i_cfg_data;
                    REG_IMAG_STEP:   r_imag_step   <= i_cfg_data[STEP_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            // indexes are latched as given, with no wrap
            r_row   <= i_row_index;
            r_col   <= i_column_index;
            r_x     <= '0;
            r_y     <= '0;
            r_count <= '0;
        end
        if (r_state == S_CI) begin
            r_cr <= c_sat;
        end
        if (r_state == S_CIW) begin
            r_ci <= c_sat;
        end
        if (r_state == S_YY) begin
            r_xsq <= prod_sq;
        end
        if (r_state == S_XY) begin
            r_ysq <= prod_sq;
        end
        if (r_state == S_UPD) begin
            r_x     <= nx;
            r_y     <= ny;
            r_count <= n_count;
        end
        if (out_load) begin
            r_out_count  <= r_count;
            r_out_inside <= (r_count >= r_max_iter);
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_iteration_count = r_out_count;
    assign o_inside_set      = r_out_inside;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_in_ready)
        else $error("input taken while a pixel is in progress");

    a_count_below_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_XX || r_state == S_YY || r_state == S_XY || r_state == S_UPD)
        |-> (r_count < r_max_iter))
        else $error("iteration count ran past the limit");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == S_DONE)
        else $error("result raised outside the done state");

    a_inside_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_inside_set) |-> (o_iteration_count == r_max_iter))
        else $error("inside flag set with count below the limit");

endmodule
`default_nettype wire

// ===== sim/mandelbrot_escape_time_pixel_checker.sv =====
module mandelbrot_escape_time_pixel_checker (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_valid,
    input  wire                             i_cfg_ready,
    input  wire [mbrot_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [mbrot_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    input  wire                             i_in_valid,
    input  wire                             i_in_ready,
    input  wire [mbrot_pkg::IDX_W-1:0]      i_row_index,
    input  wire [mbrot_pkg::IDX_W-1:0]      i_column_index,
    input  wire                             i_out_valid,
    input  wire                             i_out_ready,
    input  wire [mbrot_pkg::CNT_W-1:0]      i_iteration_count,
    input  wire                             i_inside_set,
    output int                              o_fail_count,
    output int                              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import mbrot_pkg::*;

    localparam longint COORD_HI   = 64'sd2147483647;
    localparam longint COORD_LO   = -64'sd2147483648;
    localparam longint ESCAPE_SQ  = 64'sd4 <<< FRAC_BITS;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             in_set;
    } t_pixel_result;

    logic [CNT_W-1:0]  max_iter_r;
    t_coord            real_origin_r;
    logic [STEP_W-1:0] real_step_r;
    t_coord            imag_origin_r;
    logic [STEP_W-1:0] imag_step_r;

    t_pixel_result predicted_pixels[$];
    int            errors = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic t_coord clamp_coord(input longint v);
        if (v > COORD_HI) begin
            return t_coord'(COORD_HI);
        end else if (v < COORD_LO) begin
            return t_coord'(COORD_LO);
        end
        return t_coord'(v);
    endfunction

    function automatic t_pixel_result escape_time(input logic [IDX_W-1:0] row,
                                                  input logic [IDX_W-1:0] col);
        t_coord        cr, ci, x, y;
        longint        xsq, ysq, xy;
        int unsigned   n;
        t_pixel_result r;
        cr = clamp_coord(longint'(real_origin_r) + longint'(col) * longint'(real_step_r));
        ci = clamp_coord(longint'(imag_origin_r) + longint'(row) * longint'(imag_step_r));
        x = '0;
        y = '0;
        n = 0;
        while (n < max_iter_r) begin
            xsq = (longint'(x) * longint'(x)) >>> FRAC_BITS;
            ysq = (longint'(y) * longint'(y)) >>> FRAC_BITS;
            if (xsq + ysq >= ESCAPE_SQ) begin
                break;
            end
            xy = (longint'(x) * longint'(y)) >>> (FRAC_BITS - 1);
            x = clamp_coord(xsq - ysq + longint'(cr));
            y = clamp_coord(xy + longint'(ci));
            n++;
        end
        r.count  = n[CNT_W-1:0];
        r.in_set = (n >= max_iter_r);
        return r;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_pixel_result want;
        if (!i_rst_n) begin
            max_iter_r    = RST_MAX_ITER;
            real_origin_r = RST_REAL_ORIGIN;
            real_step_r   = RST_REAL_STEP;
            imag_origin_r = RST_IMAG_ORIGIN;
            imag_step_r   = RST_IMAG_STEP;
            predicted_pixels.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_MAX_ITER:    max_iter_r    = i_cfg_data[CNT_W-1:0];
                    REG_REAL_ORIGIN: real_origin_r = t_coord'(i_cfg_data);
                    REG_REAL_STEP:   real_step_r   = i_cfg_data[STEP_W-1:0];
                    REG_IMAG_ORIGIN: imag_origin_r = t_coord'(i_cfg_data);
                    REG_IMAG_STEP:   imag_step_r   = i_cfg_data[STEP_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                predicted_pixels.push_back(escape_time(i_row_index, i_column_index));
            end
            if (i_out_valid && i_out_ready) begin
                if (predicted_pixels.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, got count %0d inside %0b",
                             $time, i_iteration_count, i_inside_set);
                end else begin
                    want = predicted_pixels.pop_front();
                    if (i_iteration_count !== want.count) begin
                        errors++;
                        $display("%0t: iteration_count expected %0d, got %0d",
                                 $time, want.count, i_iteration_count);
                    end
                    if (i_inside_set !== want.in_set) begin
                        errors++;
                        $display("%0t: inside_set expected %0b, got %0b",
                                 $time, want.in_set, i_inside_set);
                    end
                end
            end
        end
        o_pending    <= predicted_pixels.size();
        o_fail_count <= errors;
    end

endmodule

// ===== sim/mandelbrot_escape_time_pixel_core_tb.sv =====
module mandelbrot_escape_time_pixel_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mbrot_pkg::*;

    localparam int CLK_PERIOD      = 20;
    localparam int RESET_CYCLES    = 12;
    localparam int PHASE_PIXELS    = 60;
    localparam int HOLD_CYCLES     = 2000;
    localparam int TAIL_CYCLES     = 16;
    localparam int IDX_MAX         = (1 << IDX_W) - 1;
    localparam int Q_ONE           = 1 << FRAC_BITS;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_cfg_valid    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index    = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data     = '0;
    logic                 i_in_valid     = 1'b0;
    logic [IDX_W-1:0]     i_row_index    = '0;
    logic [IDX_W-1:0]     i_column_index = '0;
    logic                 i_out_ready    = 1'b0;
    logic                 o_cfg_ready;
    logic                 o_in_ready;
    logic                 o_out_valid;
    logic [CNT_W-1:0]     o_iteration_count;
    logic                 o_inside_set;

    int fail_count;
    int pending;
    int idle_pct  = 0;
    int stall_pct = 0;
    bit hold_req  = 1'b0;
    bit hold_done = 1'b0;

    mandelbrot_escape_time_pixel_core dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_row_index       (i_row_index),
        .i_column_index    (i_column_index),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_iteration_count (o_iteration_count),
        .o_inside_set      (o_inside_set)
    );

    mandelbrot_escape_time_pixel_checker checker_i (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .i_in_ready        (o_in_ready),
        .i_row_index       (i_row_index),
        .i_column_index    (i_column_index),
        .i_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .i_iteration_count (o_iteration_count),
        .i_inside_set      (o_inside_set),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        #200ms;
        $display("CHECKS FAILED");
        $finish;
    end

    // result side; one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic load_view(input logic [31:0] max_d, input logic [31:0] re_org,
                             input logic [31:0] re_stp, input logic [31:0] im_org,
                             input logic [31:0] im_stp);
        write_reg(REG_MAX_ITER, max_d);
        write_reg(REG_REAL_ORIGIN, re_org);
        write_reg(REG_REAL_STEP, re_stp);
        write_reg(REG_IMAG_ORIGIN, im_org);
        write_reg(REG_IMAG_STEP, im_stp);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic offer_pixel(input int row, input int col);
        if ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        i_in_valid     <= 1'b1;
        i_row_index    <= IDX_W'(row);
        i_column_index <= IDX_W'(col);
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic drain;
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic random_view;
        logic [31:0] max_d;
        max_d = {16'($urandom), 16'($urandom_range(128, 1))};
        if ($urandom_range(5) == 0) begin
            load_view(max_d, $urandom, $urandom, $urandom, $urandom);
        end else begin
            // window around the set, up to about 4.0 across
            load_view(max_d,
                      32'($urandom_range(3 * Q_ONE / 2) - 9 * Q_ONE / 4),
                      {3'($urandom), 29'($urandom_range(1 << 20, 1))},
                      32'($urandom_range(Q_ONE) - 3 * Q_ONE / 2),
                      {3'($urandom), 29'($urandom_range(1 << 20, 1))});
        end
    endtask

    task automatic random_phase(input int idle, input int stall, input bit hold);
        idle_pct  = idle;
        stall_pct = stall;
        random_view();
        hold_req  = hold;
        repeat (PHASE_PIXELS) offer_pixel($urandom_range(IDX_MAX), $urandom_range(IDX_MAX));
        drain();
    endtask

    initial begin : stimulus
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset view, limit 2000
        offer_pixel(0, 0);
        offer_pixel(IDX_MAX, IDX_MAX);
        offer_pixel(400, 533);
        offer_pixel(0, IDX_MAX);
        offer_pixel(IDX_MAX, 0);
        drain();

        // unmapped indexes, then zero limit
        write_reg(REG_SPARE_FIRST, $urandom);
        write_reg(REG_SPARE_FIRST + 3'd1, $urandom);
        write_reg(REG_SPARE_FIRST + 3'd2, $urandom);
        load_view(32'hFFFF_0000, 32'h0, 32'h0, 32'h0, 32'h0);
        offer_pixel(5, 7);
        drain();

        load_view(32'd1, 32'h0, 32'h0, 32'h0, 32'h0);
        offer_pixel(0, 0);
        drain();

        // extreme origins and steps, c saturates
        load_view(32'h0000_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0);
        offer_pixel(0, 0);
        offer_pixel(0, IDX_MAX);
        offer_pixel(IDX_MAX, IDX_MAX);
        offer_pixel(682, 341);
        drain();

        // real axis: c = -2 boundary, c = 0 runs to the full limit
        load_view(32'h0000_FFFF, 32'(-2 * Q_ONE), 32'(Q_ONE / 4), 32'h0, 32'h0);
        offer_pixel(0, 0);
        offer_pixel(0, 8);
        offer_pixel(0, 10);
        offer_pixel(0, IDX_MAX);
        drain();

        random_phase(0, 0, 1'b0);
        random_phase(45, 0, 1'b0);
        random_phase(0, 45, 1'b0);
        random_phase(28, 28, 1'b0);
        random_phase(0, 0, 1'b1);

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
